>>> rtl/hdlc_rx_deframer_defines.svh
// Assertion macros shared by the HDLC receive deframer modules
`ifndef HDLC_RX_DEFRAMER_DEFINES_SVH
`define HDLC_RX_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define HDLCRX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HDLCRX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hdlcrx_pkg.sv
// Types, constants and bit-step functions of the HDLC receive deframer
package hdlcrx_pkg;

   localparam int LEN_W = 13;
   localparam int CNT_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SEVEN_BIT_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FRAME_LEN  = 1'b1;

   localparam logic [15:0] FCS_POLY = 16'h8408;
   localparam logic [15:0] FCS_INIT = 16'hFFFF;
   localparam logic [15:0] FCS_GOOD = 16'hF0B8;

   localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 13'd3;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'b001,
      PH_OPEN  = 3'b010,
      PH_FRAME = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      ST_GOOD     = 3'd0,
      ST_CRC_ERR  = 3'd1,
      ST_SHORT    = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_ABORT    = 3'd4
   } status_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      phase_type        phase;
      logic [2:0]       ones;
      logic [2:0]       pos;
      logic [7:0]       shift;
      logic [LEN_W-1:0] fbytes;
   } walk_type;

   typedef struct packed {
      logic             byte_v;
      logic [7:0]       byte_val;
      logic             end_v;
      status_type       end_st;
      logic             crc_chk;
      logic [LEN_W-1:0] end_len;
      logic             clr;
   } ev_type;

   typedef struct packed {
      walk_type w;
      ev_type   e;
   } step_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      status_type       frame_status;
      logic [LEN_W-1:0] frame_length;
      logic [CNT_W-1:0] good_frames;
      logic [CNT_W-1:0] error_frames;
      logic             last_of_input;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } pair_type;

   function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] c;
      c = fcs ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic step_type clear_frame(input step_type s);
      step_type r;
      r = s;
      r.w.pos = 3'd0;
      r.w.shift = 8'd0;
      r.w.fbytes = '0;
      r.e.clr = 1'b1;
      return r;
   endfunction

   function automatic step_type walk_bit(input step_type cur, input logic b,
                                         input logic [LEN_W-1:0] lim);
      step_type   nx;
      logic       data_v;
      logic [2:0] ones_n;
      logic [7:0] shift_n;
      nx = cur;
      data_v = 1'b0;
      if (b) begin
         ones_n = (cur.w.ones == 3'd7) ? 3'd7 : cur.w.ones + 3'd1;
         nx.w.ones = ones_n;
         if (ones_n == 3'd7) begin
            if (cur.w.phase != PH_HUNT) begin
               if (cur.w.phase == PH_FRAME) begin
                  nx.e.end_v = 1'b1;
                  nx.e.end_st = ST_ABORT;
                  nx.e.crc_chk = 1'b0;
                  nx.e.end_len = cur.w.fbytes;
               end
               nx.w.phase = PH_HUNT;
               nx = clear_frame(nx);
            end
         end else if (cur.w.phase != PH_HUNT) begin
            data_v = 1'b1;
         end
      end else begin
         nx.w.ones = 3'd0;
         if (cur.w.ones == 3'd6) begin
            if (cur.w.phase == PH_FRAME) begin
               nx.e.end_v = 1'b1;
               nx.e.end_len = cur.w.fbytes;
               if (cur.w.fbytes < MIN_FRAME_LEN) begin
                  nx.e.end_st = ST_SHORT;
                  nx.e.crc_chk = 1'b0;
               end else begin
                  nx.e.end_st = ST_GOOD;
                  nx.e.crc_chk = 1'b1;
               end
            end
            nx.w.phase = PH_OPEN;
            nx = clear_frame(nx);
         end else if (cur.w.ones != 3'd5 && cur.w.phase != PH_HUNT) begin
            data_v = 1'b1;
         end
      end
      if (data_v) begin
         shift_n = cur.w.shift | (8'(b) << cur.w.pos);
         if (cur.w.pos == 3'd7) begin
            if (cur.w.fbytes >= lim) begin
               nx.e.end_v = 1'b1;
               nx.e.end_st = ST_OVERFLOW;
               nx.e.crc_chk = 1'b0;
               nx.e.end_len = lim + 13'd1;
               nx.w.phase = PH_HUNT;
               nx = clear_frame(nx);
            end else begin
               nx.e.byte_v = 1'b1;
               nx.e.byte_val = shift_n;
               nx.w.fbytes = cur.w.fbytes + 13'd1;
               nx.w.phase = PH_FRAME;
               nx.w.pos = 3'd0;
               nx.w.shift = 8'd0;
            end
         end else begin
            nx.w.pos = cur.w.pos + 3'd1;
            nx.w.shift = shift_n;
         end
      end
      return nx;
   endfunction

endpackage

>>> rtl/hdlcrx_if.sv
// Request and response channel interfaces of the HDLC receive deframer
interface hdlcrx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;

   modport source (output valid, output raw_byte, input ready);
   modport sink (input valid, input raw_byte, output ready);
endinterface

interface hdlcrx_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [2:0]  frame_status;
   logic [12:0] frame_length;
   logic [31:0] good_frames;
   logic [31:0] error_frames;
   logic        last_of_input;

   modport source (output valid, output kind, output data_byte, output frame_status,
                   output frame_length, output good_frames, output error_frames,
                   output last_of_input, input ready);
   modport sink (input valid, input kind, input data_byte, input frame_status,
                 input frame_length, input good_frames, input error_frames,
                 input last_of_input, output ready);
endinterface

>>> rtl/hdlcrx_bit_walker.sv
// Input register, flag hunt, zero removal and byte assembly over one line byte
module hdlcrx_bit_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [7:0]                    in_byte,
   output logic                          in_ready,
   input  logic                          seven_bit_mode,
   input  logic [hdlcrx_pkg::LEN_W-1:0]  frame_limit,
   input  logic                          chk_go,
   output logic                          ev_valid,
   output hdlcrx_pkg::ev_type            ev
);

   logic                   raw_v_ff;
   logic [7:0]             raw_ff;
   logic                   ev_v_ff;
   hdlcrx_pkg::ev_type     ev_ff;
   hdlcrx_pkg::walk_type   walk_ff;
   hdlcrx_pkg::step_type   st [0:8];
   logic                   walk_go;
   logic                   ev_free;

   assign ev_free  = !ev_v_ff || chk_go;
   assign walk_go  = raw_v_ff && ev_free;
   assign in_ready = !raw_v_ff || walk_go;
   assign ev_valid = ev_v_ff;
   assign ev       = ev_ff;

   always_comb begin
      st[0].w = walk_ff;
      st[0].e = '0;
      for (int i = 0; i < 8; i++) begin
         if (seven_bit_mode && i == 7) begin
            st[i+1] = st[i];
         end else begin
            st[i+1] = hdlcrx_pkg::walk_bit(st[i], raw_ff[i], frame_limit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_v_ff <= 1'b0;
         ev_v_ff <= 1'b0;
         walk_ff.phase <= hdlcrx_pkg::PH_HUNT;
         walk_ff.ones <= 3'd0;
         walk_ff.pos <= 3'd0;
         walk_ff.shift <= 8'd0;
         walk_ff.fbytes <= '0;
      end else begin
         if (in_valid && in_ready) begin
            raw_v_ff <= 1'b1;
         end else if (walk_go) begin
            raw_v_ff <= 1'b0;
         end
         if (walk_go) begin
            ev_v_ff <= 1'b1;
            walk_ff <= st[8].w;
         end else if (chk_go) begin
            ev_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         raw_ff <= in_byte;
      end
      if (walk_go) begin
         ev_ff <= st[8].e;
      end
   end

endmodule

>>> rtl/hdlcrx_frame_check.sv
// FCS-16 residue check, frame verdict and running frame counters
`include "hdlc_rx_deframer_defines.svh"

module hdlcrx_frame_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  hdlcrx_pkg::ev_type    ev,
   input  logic                  out_free,
   output logic                  chk_go,
   output hdlcrx_pkg::pair_type  pair
);

   logic [15:0]                         fcs_ff;
   logic [15:0]                         fcs_in;
   logic [15:0]                         fcs_b;
   logic [hdlcrx_pkg::CNT_W-1:0]        good_ff;
   logic [hdlcrx_pkg::CNT_W-1:0]        good_in;
   logic [hdlcrx_pkg::CNT_W-1:0]        err_ff;
   logic [hdlcrx_pkg::CNT_W-1:0]        err_in;
   hdlcrx_pkg::status_type              end_st;
   logic                                end_ok;
   hdlcrx_pkg::result_type              byte_res;
   hdlcrx_pkg::result_type              end_res;

   assign chk_go = ev_valid && out_free;

   always_comb begin
      fcs_b = ev.byte_v ? hdlcrx_pkg::fcs_update(fcs_ff, ev.byte_val) : fcs_ff;
      if (ev.crc_chk) begin
         end_st = (fcs_b == hdlcrx_pkg::FCS_GOOD) ? hdlcrx_pkg::ST_GOOD
                                                  : hdlcrx_pkg::ST_CRC_ERR;
      end else begin
         end_st = ev.end_st;
      end
      end_ok = ev.end_v && (end_st == hdlcrx_pkg::ST_GOOD);
      good_in = good_ff + 32'(end_ok);
      err_in = err_ff + 32'(ev.end_v && !end_ok);
      fcs_in = ev.clr ? hdlcrx_pkg::FCS_INIT : fcs_b;

      byte_res.kind = hdlcrx_pkg::KIND_BYTE;
      byte_res.data_byte = ev.byte_val;
      byte_res.frame_status = hdlcrx_pkg::ST_GOOD;
      byte_res.frame_length = '0;
      byte_res.good_frames = good_ff;
      byte_res.error_frames = err_ff;
      byte_res.last_of_input = !ev.end_v;

      end_res.kind = hdlcrx_pkg::KIND_END;
      end_res.data_byte = 8'd0;
      end_res.frame_status = end_st;
      end_res.frame_length = ev.end_len;
      end_res.good_frames = good_in;
      end_res.error_frames = err_in;
      end_res.last_of_input = 1'b1;

      pair.cnt = 2'(ev.byte_v) + 2'(ev.end_v);
      pair.r0 = ev.byte_v ? byte_res : end_res;
      pair.r1 = end_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcs_ff <= hdlcrx_pkg::FCS_INIT;
         good_ff <= '0;
         err_ff <= '0;
      end else if (chk_go) begin
         fcs_ff <= fcs_in;
         good_ff <= good_in;
         err_ff <= err_in;
      end
   end

   `HDLCRX_ASSERT_NXT(a_err_count_step, clock, reset, chk_go && ev.end_v && !end_ok, err_ff == $past(err_ff) + 32'd1, "error count did not advance on a bad frame")

endmodule

>>> rtl/hdlcrx_out_buf.sv
// Two-entry result buffer that drains the results of one line byte in order
`include "hdlc_rx_deframer_defines.svh"

module hdlcrx_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  hdlcrx_pkg::pair_type    pair,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hdlcrx_pkg::result_type  head
);

   logic [1:0]               n_ff;
   hdlcrx_pkg::result_type   slot_ff [0:1];
   logic                     pop;

   assign rsp_valid = (n_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign out_free  = (n_ff == 2'd0) || (n_ff == 2'd1 && pop);
   assign head      = slot_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= 2'd0;
      end else if (load) begin
         n_ff <= pair.cnt;
      end else if (pop) begin
         n_ff <= n_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff[0] <= pair.r0;
         slot_ff[1] <= pair.r1;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
      end
   end

   `HDLCRX_ASSERT_IMP(a_pair_order, clock, reset, n_ff == 2'd2, slot_ff[0].kind == hdlcrx_pkg::KIND_BYTE && slot_ff[1].kind == hdlcrx_pkg::KIND_END, "held pair is not a byte followed by an end")
   `HDLCRX_ASSERT_IMP(a_single_last, clock, reset, n_ff == 2'd1, slot_ff[0].last_of_input, "lone result not marked last")
   `HDLCRX_ASSERT_IMP(a_pair_last, clock, reset, n_ff == 2'd2, !slot_ff[0].last_of_input && slot_ff[1].last_of_input, "last mark misplaced in held pair")

endmodule

>>> rtl/hdlc_rx_deframer.sv
// HDLC receive deframer: flag hunt, zero removal, FCS-16 check, frame verdicts
// A line byte accepted passes the input register, the event register and the result
// buffer. One line byte per cycle when it yields at most one result and the result
// port is not stalled; after a data byte and end verdict the next waits for both to go.
// Reset (synchronous): hunt for a flag, FCS 0xFFFF, counters zero, eight-bit mode,
// frame limit 4096 bytes or MAX_FRAME_BYTES if smaller.
module hdlc_rx_deframer #(
   parameter int MAX_FRAME_BYTES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   hdlcrx_req_if.sink                           req_ch,
   hdlcrx_rsp_if.source                         rsp_ch,
   input  logic                                 csr_we,
   input  logic [hdlcrx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hdlcrx_pkg::LEN_W-1:0]         csr_wdata
);

   localparam logic [hdlcrx_pkg::LEN_W-1:0] LIM_MAX =
      13'((MAX_FRAME_BYTES > 8191) ? 8191 : MAX_FRAME_BYTES);
   localparam logic [hdlcrx_pkg::LEN_W-1:0] LIM_RST =
      13'((MAX_FRAME_BYTES < 4096) ? MAX_FRAME_BYTES : 4096);

   logic                              seven_ff;
   logic [hdlcrx_pkg::LEN_W-1:0]      lim_ff;
   logic [hdlcrx_pkg::LEN_W-1:0]      lim_in;
   logic                              chk_go;
   logic                              ev_valid;
   hdlcrx_pkg::ev_type                ev;
   logic                              out_free;
   hdlcrx_pkg::pair_type              pair;
   hdlcrx_pkg::result_type            head;

   always_comb begin
      if (csr_wdata < hdlcrx_pkg::MIN_FRAME_LEN) begin
         lim_in = hdlcrx_pkg::MIN_FRAME_LEN;
      end else if (32'(csr_wdata) > MAX_FRAME_BYTES) begin
         lim_in = LIM_MAX;
      end else begin
         lim_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seven_ff <= 1'b0;
         lim_ff <= LIM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hdlcrx_pkg::CSR_SEVEN_BIT_MODE: seven_ff <= csr_wdata[0];
            hdlcrx_pkg::CSR_MAX_FRAME_LEN:  lim_ff <= lim_in;
            default: begin
            end
         endcase
      end
   end

   hdlcrx_bit_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_ch.valid),
      .in_byte        (req_ch.raw_byte),
      .in_ready       (req_ch.ready),
      .seven_bit_mode (seven_ff),
      .frame_limit    (lim_ff),
      .chk_go         (chk_go),
      .ev_valid       (ev_valid),
      .ev             (ev)
   );

   hdlcrx_frame_check u_check (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (ev_valid),
      .ev       (ev),
      .out_free (out_free),
      .chk_go   (chk_go),
      .pair     (pair)
   );

   hdlcrx_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (chk_go),
      .pair      (pair),
      .out_free  (out_free),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .head      (head)
   );

   assign rsp_ch.kind          = head.kind;
   assign rsp_ch.data_byte     = head.data_byte;
   assign rsp_ch.frame_status  = head.frame_status;
   assign rsp_ch.frame_length  = head.frame_length;
   assign rsp_ch.good_frames   = head.good_frames;
   assign rsp_ch.error_frames  = head.error_frames;
   assign rsp_ch.last_of_input = head.last_of_input;

endmodule

>>> dv/hdlc_rx_deframer_test.sv
// Self-checking testbench of the HDLC receive deframer with a bit-level frame predictor
module hdlc_rx_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hdlcrx_pkg::*;

   localparam int CAP_BYTES = 4096;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_TARGET = 850;
   localparam int STEADY_TARGET = 950;
   localparam logic [7:0] FLAG_OCTET = 8'h7E;
   localparam logic [7:0] MARK_OCTET = 8'hFF;

   typedef enum int {FR_GOOD, FR_CRC_BAD, FR_ABORTED, FR_BARE} frame_flavor;
   typedef logic [7:0] octet_list[$];

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0] csr_wdata;

   hdlcrx_req_if req_ch();
   hdlcrx_rsp_if rsp_ch();

   hdlc_rx_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // receiver state mirror
   phase_type        rx_phase;
   logic [2:0]       rx_ones;
   logic [2:0]       rx_pos;
   logic [7:0]       rx_shift;
   logic [15:0]      rx_fcs;
   logic [LEN_W-1:0] rx_count;
   logic [CNT_W-1:0] good_total;
   logic [CNT_W-1:0] bad_total;
   logic             cfg_seven;
   logic [LEN_W-1:0] cfg_max_len;
   result_type       step_out[2];
   int               step_n;
   result_type       due_results[$];

   // line side
   bit line_bits[$];
   int tx_ones = 0;
   int sent_count = 0;
   int failures = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc16_x25(logic [15:0] crc, logic [7:0] octet);
      logic [15:0] c;
      c = crc ^ {8'h00, octet};
      repeat (8) begin
         if (c[0])
            c = (c >> 1) ^ FCS_POLY;
         else
            c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [LEN_W-1:0] frame_cap();
      if (cfg_max_len < MIN_FRAME_LEN)
         return MIN_FRAME_LEN;
      if (cfg_max_len > CAP_BYTES)
         return LEN_W'(CAP_BYTES);
      return cfg_max_len;
   endfunction

   function automatic void restart_frame();
      rx_pos = 3'd0;
      rx_shift = 8'h00;
      rx_fcs = FCS_INIT;
      rx_count = '0;
   endfunction

   function automatic void add_result(kind_type k, logic [7:0] data, status_type st,
                                      logic [LEN_W-1:0] len);
      result_type r;
      if (step_n >= 2)
         return;
      r.kind = k;
      r.data_byte = data;
      r.frame_status = st;
      r.frame_length = len;
      r.good_frames = good_total;
      r.error_frames = bad_total;
      r.last_of_input = 1'b0;
      step_out[step_n] = r;
      step_n++;
   endfunction

   function automatic void take_data_bit(logic b);
      rx_shift = rx_shift | (8'(b) << rx_pos);
      if (rx_pos != 3'd7) begin
         rx_pos++;
         return;
      end
      if (rx_count >= frame_cap()) begin
         bad_total++;
         add_result(KIND_END, 8'h00, ST_OVERFLOW, frame_cap() + 13'd1);
         restart_frame();
         rx_phase = PH_HUNT;
         return;
      end
      rx_fcs = crc16_x25(rx_fcs, rx_shift);
      rx_count++;
      add_result(KIND_BYTE, rx_shift, ST_GOOD, '0);
      rx_phase = PH_FRAME;
      rx_pos = 3'd0;
      rx_shift = 8'h00;
   endfunction

   function automatic void deframe_line_byte(logic [7:0] raw);
      status_type verdict;
      step_n = 0;
      for (int i = 0; i < (cfg_seven ? 7 : 8); i++) begin
         if (raw[i]) begin
            if (rx_ones != 3'd7)
               rx_ones++;
            if (rx_ones == 3'd7) begin
               if (rx_phase != PH_HUNT) begin
                  if (rx_phase == PH_FRAME) begin
                     bad_total++;
                     add_result(KIND_END, 8'h00, ST_ABORT, rx_count);
                  end
                  rx_phase = PH_HUNT;
                  restart_frame();
               end
            end else if (rx_phase != PH_HUNT) begin
               take_data_bit(1'b1);
            end
         end else begin
            if (rx_ones == 3'd6) begin
               if (rx_phase == PH_FRAME) begin
                  if (rx_count < MIN_FRAME_LEN)
                     verdict = ST_SHORT;
                  else if (rx_fcs == FCS_GOOD)
                     verdict = ST_GOOD;
                  else
                     verdict = ST_CRC_ERR;
                  if (verdict == ST_GOOD)
                     good_total++;
                  else
                     bad_total++;
                  add_result(KIND_END, 8'h00, verdict, rx_count);
               end
               rx_phase = PH_OPEN;
               restart_frame();
            end else if (rx_ones != 3'd5 && rx_phase != PH_HUNT) begin
               take_data_bit(1'b0);
            end
            rx_ones = 3'd0;
         end
      end
      if (step_n > 0)
         step_out[step_n-1].last_of_input = 1'b1;
      for (int k = 0; k < step_n; k++)
         due_results.push_back(step_out[k]);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d data %0h status %0d length %0d",
                   rsp_ch.kind, rsp_ch.data_byte, rsp_ch.frame_status, rsp_ch.frame_length);
            failures++;
         end else begin
            want = due_results.pop_front();
            check_field("kind", want.kind, rsp_ch.kind);
            check_field("data_byte", want.data_byte, rsp_ch.data_byte);
            check_field("frame_status", want.frame_status, rsp_ch.frame_status);
            check_field("frame_length", want.frame_length, rsp_ch.frame_length);
            check_field("good_frames", want.good_frames, rsp_ch.good_frames);
            check_field("error_frames", want.error_frames, rsp_ch.error_frames);
            check_field("last_of_input", want.last_of_input, rsp_ch.last_of_input);
         end
      end
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("hdlc_rx_deframer regression: fail");
      $finish;
   end

   task automatic send_line_byte(logic [7:0] octet);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_byte <= octet;
      do @(posedge clock); while (!req_ch.ready);
      deframe_line_byte(octet);
      sent_count++;
      @(negedge clock);
   endtask

   // pack queued line bits into line bytes; pad with marks to a whole byte on request
   task automatic drain_line_bits(bit pad);
      logic [7:0] octet;
      int width;
      width = cfg_seven ? 7 : 8;
      if (pad) begin
         while (line_bits.size() % width != 0)
            line_bits.push_back(1'b1);
         tx_ones = 0;
      end
      while (line_bits.size() >= width) begin
         octet = 8'($urandom_range(0, 255));
         for (int i = 0; i < width; i++)
            octet[i] = line_bits.pop_front();
         send_line_byte(octet);
      end
   endtask

   task automatic push_octet(logic [7:0] octet, bit stuffed);
      for (int i = 0; i < 8; i++) begin
         line_bits.push_back(octet[i]);
         if (!stuffed || !octet[i]) begin
            tx_ones = 0;
         end else begin
            tx_ones++;
            if (tx_ones == 5) begin
               line_bits.push_back(1'b0);
               tx_ones = 0;
            end
         end
      end
   endtask

   function automatic octet_list random_payload(int len);
      octet_list q;
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 7);
         q.push_back(pick == 0 ? FLAG_OCTET : pick == 1 ? MARK_OCTET : pick == 2 ? 8'h00 :
                     8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   task automatic send_frame(octet_list payload, frame_flavor flavor, bit lead_flag);
      logic [15:0] crc;
      crc = FCS_INIT;
      if (lead_flag)
         push_octet(FLAG_OCTET, 1'b0);
      foreach (payload[i]) begin
         push_octet(payload[i], 1'b1);
         crc = crc16_x25(crc, payload[i]);
      end
      if (flavor == FR_GOOD || flavor == FR_CRC_BAD) begin
         crc = ~crc;
         if (flavor == FR_CRC_BAD)
            crc[$urandom_range(0, 15)] ^= 1'b1;
         push_octet(crc[7:0], 1'b1);
         push_octet(crc[15:8], 1'b1);
      end
      if (flavor == FR_ABORTED)
         push_octet(MARK_OCTET, 1'b0);
      else
         push_octet(FLAG_OCTET, 1'b0);
      drain_line_bits(1'b0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SEVEN_BIT_MODE)
         cfg_seven = value[0];
      else
         cfg_max_len = value;
      @(negedge clock);
   endtask

   // flush the line, then wait out every result and the pipeline
   task automatic settle();
      drain_line_bits(1'b1);
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_good_frames();
      send_frame('{MARK_OCTET}, FR_GOOD, 1'b1);
      send_frame('{FLAG_OCTET, 8'h00}, FR_GOOD, 1'b0);
      settle();
   endtask

   task automatic test_short_and_empty();
      send_frame(random_payload(0), FR_BARE, 1'b1);
      send_frame('{8'hA5}, FR_BARE, 1'b0);
      send_frame('{8'h5A, 8'h3C}, FR_BARE, 1'b0);
      line_bits.push_back(1'b1);
      line_bits.push_back(1'b0);
      line_bits.push_back(1'b1);
      push_octet(FLAG_OCTET, 1'b0);
      settle();
   endtask

   task automatic test_crc_error();
      send_frame('{8'h12, 8'h34}, FR_CRC_BAD, 1'b1);
      settle();
   endtask

   task automatic test_abort();
      send_frame('{8'h81, 8'h42}, FR_ABORTED, 1'b1);
      send_frame(random_payload(0), FR_ABORTED, 1'b1);
      settle();
      send_line_byte(8'hFF);
      send_line_byte(8'h00);
      send_line_byte(8'hFF);
      settle();
   endtask

   task automatic test_frame_limit();
      write_csr(CSR_MAX_FRAME_LEN, '0);
      send_frame('{8'h01}, FR_GOOD, 1'b1);
      send_frame('{8'h01, 8'h02}, FR_GOOD, 1'b1);
      settle();
      write_csr(CSR_MAX_FRAME_LEN, '1);
      send_frame(random_payload(6), FR_GOOD, 1'b1);
      settle();
   endtask

   task automatic test_seven_bit_mode();
      write_csr(CSR_SEVEN_BIT_MODE, LEN_W'(1));
      send_frame(random_payload(3), FR_GOOD, 1'b1);
      send_frame(random_payload(2), FR_CRC_BAD, 1'b0);
      settle();
      write_csr(CSR_SEVEN_BIT_MODE, '0);
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (4)
         send_frame(random_payload(10), FR_GOOD, 1'b1);
      settle();
      idle_on = 1'b1;
   endtask

   task automatic pick_random_frame();
      int roll;
      bit lead_flag;
      roll = $urandom_range(0, 99);
      lead_flag = $urandom_range(0, 3) != 0;
      if (roll < 70) begin
         send_frame(random_payload($urandom_range(1, 12)), FR_GOOD, lead_flag);
      end else if (roll < 80) begin
         send_frame(random_payload($urandom_range(1, 12)), FR_CRC_BAD, lead_flag);
      end else if (roll < 88) begin
         send_frame(random_payload($urandom_range(0, 8)), FR_ABORTED, lead_flag);
      end else if (roll < 95) begin
         send_frame(random_payload($urandom_range(0, 3)), FR_BARE, lead_flag);
      end else begin
         drain_line_bits(1'b1);
         repeat ($urandom_range(1, 4))
            send_line_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_random_traffic();
      logic [LEN_W-1:0] limit;
      while (sent_count < RANDOM_TARGET) begin
         if ($urandom_range(0, 39) == 0) begin
            settle();
            write_csr(CSR_SEVEN_BIT_MODE, LEN_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 5))
               0: limit = '0;
               1: limit = MIN_FRAME_LEN;
               2: limit = LEN_W'(CAP_BYTES);
               3: limit = '1;
               default: limit = LEN_W'($urandom_range(3, 16));
            endcase
            write_csr(CSR_MAX_FRAME_LEN, limit);
         end
         pick_random_frame();
      end
      settle();
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      while (sent_count < STEADY_TARGET)
         pick_random_frame();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SEVEN_BIT_MODE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.raw_byte = 8'h00;
      rx_phase = PH_HUNT;
      rx_ones = 3'd0;
      restart_frame();
      good_total = '0;
      bad_total = '0;
      cfg_seven = 1'b0;
      cfg_max_len = LEN_W'(CAP_BYTES);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_good_frames();
      test_short_and_empty();
      test_crc_error();
      test_abort();
      test_frame_limit();
      test_seven_bit_mode();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();
      settle();
      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("hdlc_rx_deframer regression: pass");
      else
         $display("hdlc_rx_deframer regression: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/hdlcrx_pkg.sv
rtl/hdlcrx_if.sv
rtl/hdlcrx_bit_walker.sv
rtl/hdlcrx_frame_check.sv
rtl/hdlcrx_out_buf.sv
rtl/hdlc_rx_deframer.sv
dv/hdlc_rx_deframer_test.sv
